[design/lcm_linear_interp_resampler_defines.svh]
// ----------------------------------------------------------------------------
// Resampler assertion macros
// Shared concurrent assertion forms for the resampler checker.
// ----------------------------------------------------------------------------
`ifndef LCM_LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define LCM_LINEAR_INTERP_RESAMPLER_DEFINES_SVH

// Assertion that is switched off while reset is high.
`define LIR_ASSERT_DIS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset.
`define LIR_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/lir_pkg.sv]
// ----------------------------------------------------------------------------
// Resampler package
// Fixed widths, register indexes, sequencer states and divider control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lir_pkg;

  localparam int STEP_BITS    = 16;
  localparam int PHASE_BITS   = 17;
  localparam int CFG_IDX_BITS = 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_STEP  = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_STEP = 8'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_CHECK,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT,
    ST_SKIP_GO,
    ST_SKIP_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[design/lir_if.sv]
// ----------------------------------------------------------------------------
// Resampler channel interfaces
// Sample, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lir_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface lir_result_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] out_sample;
  logic                   run_end;

  modport source (output valid, output out_sample, output run_end, input ready);
  modport sink   (input valid, input out_sample, input run_end, output ready);
endinterface

interface lir_cfg_if
  import lir_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [STEP_BITS-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/lir_divider.sv]
// ----------------------------------------------------------------------------
// Resampler shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lir_divider
  import lir_pkg::*;
#(
  parameter int DW = 33
) (
  input  logic                 clk,
  input  logic                 rst,
  input  div_ctrl_t            ctrl,
  output div_stat_t            stat,
  input  logic [DW-1:0]        dividend,
  input  logic [STEP_BITS-1:0] divisor,
  output logic [DW-1:0]        quotient,
  output logic [STEP_BITS-1:0] remainder
);

  localparam int CNT_BITS = $clog2(DW + 1);

  logic                 busy;
  logic                 done;
  logic [CNT_BITS-1:0]  cnt;
  logic [DW-1:0]        quo;
  logic [STEP_BITS-1:0] rem;
  logic [STEP_BITS-1:0] dvs;
  logic [STEP_BITS:0]   trial;
  logic                 fits;

  assign trial = {rem, quo[DW-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start && !busy) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], fits};
      rem <= fits ? STEP_BITS'(trial - {1'b0, dvs}) : trial[STEP_BITS-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

[design/lcm_linear_interp_resampler.sv]
// ----------------------------------------------------------------------------
// Linear interpolation sample rate converter
// Resamples signed audio on a common time grid by straight-line interpolation.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake      Payload
//  samples   in    valid/ready    in_sample  (SAMPLE_BITS, signed)
//  results   out   valid/ready    out_sample (SAMPLE_BITS, signed), run_end
//  cfg       in    valid/ready    index (8 bits), data (16 bits)
//
//  The first sample after reset goes through ST_FIRST straight into the
//  output register. For a later sample, each result takes a multiply and a
//  division, and output points past the run cap are skipped with one further
//  division; both run on the shared one-bit-per-cycle divider. Reset is
//  synchronous and the block takes requests in the first cycle after reset.
//  A stalled result channel holds the sequencer at the next result; the
//  sample channel stays low while busy.
//
`timescale 1ns / 1ps

module lcm_linear_interp_resampler
  import lir_pkg::*;
#(
  parameter int MAX_RUN     = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  lir_sample_if.sink    samples,
  lir_result_if.source  results,
  lir_cfg_if.sink       cfg
);

  // The product of the difference magnitude and the phase is this wide, and
  // the divider works on a dividend of the same width.
  localparam int DW = SAMPLE_BITS + PHASE_BITS;
  localparam int CW = $clog2(MAX_RUN + 1);
  localparam logic [CW-1:0] RUN_LIMIT = CW'(MAX_RUN);
  localparam logic [CW-1:0] RUN_LAST  = CW'(MAX_RUN - 1);

  // Configuration registers.
  logic [STEP_BITS-1:0] input_step;
  logic [STEP_BITS-1:0] output_step;
  logic [STEP_BITS-1:0] istep;
  logic [STEP_BITS-1:0] ostep;

  // Sequencer and interpolation state.
  state_t                 state;
  state_t                 state_next;
  logic                   started;
  logic [CW-1:0]          count;
  logic [SAMPLE_BITS-1:0] prev;
  logic [SAMPLE_BITS-1:0] cur;
  logic [PHASE_BITS-1:0]  phase;
  logic                   diff_neg;
  logic [SAMPLE_BITS:0]   diff_mag;
  logic [DW-1:0]          product;

  // Output register.
  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_sample;
  logic                   run_end;

  // Divider connections.
  div_ctrl_t            div_ctrl;
  div_stat_t            div_stat;
  logic [DW-1:0]        div_dividend;
  logic [DW-1:0]        div_quotient;
  logic [STEP_BITS-1:0] div_divisor;
  logic [STEP_BITS-1:0] div_remainder;

  // Combinational helpers.
  logic                   in_accept;
  logic                   slot_free;
  logic                   out_load;
  logic                   out_last;
  logic [SAMPLE_BITS-1:0] out_value;
  logic [SAMPLE_BITS:0]   diff_full;
  logic [SAMPLE_BITS:0]   q_signed;
  logic [PHASE_BITS-1:0]  phase_plus;
  logic [STEP_BITS-1:0]   gap;
  logic                   phase_below;

  // A step register that holds zero acts as a step of one.
  assign istep = (input_step == '0) ? STEP_BITS'(1) : input_step;
  assign ostep = (output_step == '0) ? STEP_BITS'(1) : output_step;

  assign in_accept   = samples.valid && samples.ready;
  assign slot_free   = !out_valid || results.ready;
  assign phase_below = (phase < {1'b0, istep});
  assign phase_plus  = phase + {1'b0, ostep};

  // The phase is below the input step whenever the gap is used, so the low
  // bits carry the whole value.
  assign gap = istep - phase[STEP_BITS-1:0];

  // Sign-extended difference between the new and the stored sample.
  assign diff_full = {samples.in_sample[SAMPLE_BITS-1], samples.in_sample}
                   - {prev[SAMPLE_BITS-1], prev};

  // The quotient magnitude never exceeds the difference magnitude, so its low
  // bits suffice. Negating the magnitude quotient truncates toward zero.
  assign q_signed  = diff_neg ? (~div_quotient[SAMPLE_BITS:0] + 1'b1)
                              : div_quotient[SAMPLE_BITS:0];
  assign out_value = prev + q_signed[SAMPLE_BITS-1:0];

  // A result closes its run when the cap is reached or the next output point
  // lies at or beyond the new sample.
  assign out_last = (count == RUN_LAST) || (phase_plus >= {1'b0, istep});

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = started ? ST_CHECK : ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (!phase_below) begin
          state_next = ST_FINISH;
        end else if (count < RUN_LIMIT) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_SKIP_GO;
        end
      end
      ST_MUL:      state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_CHECK;
        end
      end
      ST_SKIP_GO:   state_next = ST_SKIP_WAIT;
      ST_SKIP_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_IDLE;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Output decode: handshake, result load and divider requests. No sample is
  // taken while reset is held.
  always_comb begin
    samples.ready  = 1'b0;
    out_load       = 1'b0;
    div_ctrl.start = 1'b0;
    div_dividend   = product;
    div_divisor    = istep;
    case (state)
      ST_IDLE:  samples.ready = !rst;
      ST_FIRST: out_load      = slot_free;
      ST_EMIT:  out_load      = slot_free;
      ST_DIV_GO: begin
        div_ctrl.start = 1'b1;
      end
      ST_SKIP_GO: begin
        // The remainder of gap / output_step gives where the first output
        // point past the skipped ones falls.
        div_ctrl.start = 1'b1;
        div_dividend   = DW'(gap);
        div_divisor    = ostep;
      end
      default: begin
        samples.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; indexes past the register list are dropped.
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_step  <= STEP_BITS'(1);
      output_step <= STEP_BITS'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_INPUT_STEP:  input_step  <= cfg.data;
        REG_OUTPUT_STEP: output_step <= cfg.data;
        default: begin
          input_step <= input_step;
        end
      endcase
    end
  end

  // Interpolation state.
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      count   <= '0;
      prev    <= '0;
      phase   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          count <= '0;
        end
        ST_FIRST: begin
          if (slot_free) begin
            started <= 1'b1;
            prev    <= cur;
            phase   <= {1'b0, ostep};
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            count <= count + 1'b1;
            phase <= phase_plus;
          end
        end
        ST_SKIP_WAIT: begin
          if (div_stat.done) begin
            prev  <= cur;
            phase <= (div_remainder == '0) ? '0
                                           : {1'b0, ostep - div_remainder};
          end
        end
        ST_FINISH: begin
          prev  <= cur;
          phase <= phase - {1'b0, istep};
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Sample payload and the multiplier stage of the interpolation.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur      <= samples.in_sample;
      diff_neg <= diff_full[SAMPLE_BITS];
      diff_mag <= diff_full[SAMPLE_BITS] ? (~diff_full + 1'b1) : diff_full;
    end
    if (state == ST_MUL) begin
      product <= DW'(diff_mag) * DW'(phase[STEP_BITS-1:0]);
    end
  end

  // Output register: a result waits here while the next sample comes in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= (state == ST_FIRST) ? cur : out_value;
      run_end    <= (state == ST_FIRST) ? 1'b1 : out_last;
    end
  end

  assign results.valid      = out_valid;
  assign results.out_sample = out_sample;
  assign results.run_end    = run_end;

  lir_divider #(
    .DW (DW)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .stat      (div_stat),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

endmodule

[design/lir_checker.sv]
// ----------------------------------------------------------------------------
// Resampler port checker
// Watches the resampler ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lcm_linear_interp_resampler_defines.svh"

module lir_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_sample,
  input logic                   run_end
);

  // A held result keeps its valid and its payload until it is taken.
  `LIR_ASSERT_DIS(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(run_end), "result changed while stalled")

  // An accepted sample takes the block out of idle, so the sample channel is not ready in the cycle after it.
  `LIR_ASSERT_DIS(a_busy_after_accept, clk, rst, in_valid && in_ready |=> !in_ready, "sample channel ready right after a request")

  // Reset leaves no result pending, and the block is ready for a sample once
  // reset is released.
  `LIR_ASSERT_ALL(a_reset_state, clk, rst |=> !out_valid && (in_ready || rst), "bad state after reset")

endmodule

bind lcm_linear_interp_resampler lir_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_lir_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_sample (results.out_sample),
  .run_end    (results.run_end)
);
